### rtl/nec_ir_frame_transmitter_core_macros.svh
// Assertion macros shared by the transmitter checker.
`ifndef NEC_IR_FRAME_TRANSMITTER_CORE_MACROS_SVH
`define NEC_IR_FRAME_TRANSMITTER_CORE_MACROS_SVH

// Clocked check, switched off while reset is high.
`define NIRT_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds through reset.
`define NIRT_CHECK_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/nirt_pkg.sv
// Types and constants of the NEC infrared frame transmitter.
`default_nettype none
package nirt_pkg;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_LEAD_MARK  = 3'd1,
      PH_LEAD_SPACE = 3'd2,
      PH_BIT_MARK   = 3'd3,
      PH_BIT_SPACE  = 3'd4,
      PH_STOP_MARK  = 3'd5
   } phase_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_CARRIER_HALF = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAD_MARK    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAD_SPACE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_MARK     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNIT         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LSB_FIRST    = 3'd5;

   localparam logic [7:0]  RST_CARRIER_HALF = 8'd13;
   localparam logic [9:0]  RST_LEAD_MARK    = 10'd346;
   localparam logic [15:0] RST_LEAD_SPACE   = 16'd4500;
   localparam logic [7:0]  RST_BIT_MARK     = 8'd21;
   localparam logic [13:0] RST_UNIT         = 14'd562;
   localparam logic        RST_LSB_FIRST    = 1'b1;

   localparam logic [5:0]  FRAME_BITS = 6'd32;

   typedef struct packed {
      logic [7:0]  carrier_half_ticks;
      logic [9:0]  leader_mark_cycles;
      logic [15:0] leader_space_ticks;
      logic [7:0]  bit_mark_cycles;
      logic [13:0] unit_ticks;
      logic        lsb_first;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] frame_bits;
      logic [5:0]  bits_left;
      logic [15:0] tick_count;
      logic [9:0]  cycle_count;
      logic        carrier_on;
   } state_type;

   typedef struct packed {
      logic led_level;
      logic busy_res;
      logic done_res;
   } result_type;

endpackage
`default_nettype wire

### rtl/nirt_step.sv
// One step of the frame sequencer: state and item in, next state and result out.
`default_nettype none
module nirt_step (
   input  nirt_pkg::cfg_type    cfg,
   input  nirt_pkg::state_type  cur,
   input  logic                 tick,
   input  logic                 start_req,
   input  logic [7:0]           address,
   input  logic [7:0]           command,
   output nirt_pkg::state_type  nxt,
   output nirt_pkg::result_type res
);
   import nirt_pkg::*;

   logic [15:0] tick_inc;
   logic [9:0]  cycle_inc;
   logic [9:0]  mark_cycles;
   logic        half_hit;
   logic        mark_end;
   logic [4:0]  bit_num;
   logic [4:0]  bit_pos;
   logic        cur_bit;
   logic [15:0] space_limit;
   logic        space_end;
   logic        is_mark;
   logic        stop_end;
   phase_type   nxt_phase;

   assign tick_inc    = cur.tick_count + 16'd1;
   assign cycle_inc   = cur.cycle_count + 10'd1;
   assign mark_cycles = (cur.phase == PH_LEAD_MARK) ? cfg.leader_mark_cycles
                                                    : {2'b00, cfg.bit_mark_cycles};
   assign half_hit    = tick_inc >= {8'h00, cfg.carrier_half_ticks};
   assign mark_end    = half_hit && !cur.carrier_on && (cycle_inc >= mark_cycles);

   // bit index within the frame; MSB-first mirrors the index inside each byte
   assign bit_num = 5'(FRAME_BITS - cur.bits_left);
   assign bit_pos = {bit_num[4:3], cfg.lsb_first ? bit_num[2:0] : ~bit_num[2:0]};
   assign cur_bit = cur.frame_bits[bit_pos];

   always_comb begin
      if (cur.phase == PH_LEAD_SPACE) begin
         space_limit = cfg.leader_space_ticks;
      end else if (cur_bit) begin
         space_limit = {1'b0, cfg.unit_ticks, 1'b0} + {2'b00, cfg.unit_ticks};
      end else begin
         space_limit = {2'b00, cfg.unit_ticks};
      end
   end
   assign space_end = tick_inc >= space_limit;

   assign is_mark  = (cur.phase == PH_LEAD_MARK) || (cur.phase == PH_BIT_MARK) ||
                     (cur.phase == PH_STOP_MARK);
   assign stop_end = (cur.phase == PH_STOP_MARK) && tick && mark_end;

   // next phase
   always_comb begin
      nxt_phase = cur.phase;
      unique case (cur.phase)
         PH_IDLE: begin
            if (start_req) nxt_phase = PH_LEAD_MARK;
         end
         PH_LEAD_MARK: begin
            if (tick && mark_end) nxt_phase = PH_LEAD_SPACE;
         end
         PH_LEAD_SPACE: begin
            if (tick && space_end) nxt_phase = PH_BIT_MARK;
         end
         PH_BIT_MARK: begin
            if (tick && mark_end) nxt_phase = PH_BIT_SPACE;
         end
         PH_BIT_SPACE: begin
            if (tick && space_end) begin
               nxt_phase = (cur.bits_left == 6'd1) ? PH_STOP_MARK : PH_BIT_MARK;
            end
         end
         PH_STOP_MARK: begin
            if (tick && mark_end) nxt_phase = PH_IDLE;
         end
         // unused codes behave as idle, start included
         default: nxt_phase = start_req ? PH_LEAD_MARK : PH_IDLE;
      endcase
   end

   // counters, carrier and frame data
   always_comb begin
      nxt       = cur;
      nxt.phase = nxt_phase;
      if (is_mark) begin
         if (tick) begin
            nxt.tick_count = half_hit ? 16'd0 : tick_inc;
            if (half_hit) begin
               if (cur.carrier_on) begin
                  nxt.carrier_on = 1'b0;
               end else begin
                  nxt.cycle_count = cycle_inc;
                  nxt.carrier_on  = !mark_end;
                  if (stop_end) nxt.cycle_count = 10'd0;
               end
            end
         end
      end else if ((cur.phase == PH_LEAD_SPACE) || (cur.phase == PH_BIT_SPACE)) begin
         if (tick) begin
            nxt.tick_count = tick_inc;
            if (space_end) begin
               nxt.tick_count  = 16'd0;
               nxt.cycle_count = 10'd0;
               nxt.carrier_on  = 1'b1;
               nxt.bits_left   = (cur.phase == PH_LEAD_SPACE) ? FRAME_BITS
                                                              : cur.bits_left - 6'd1;
            end
         end
      end else begin
         nxt.carrier_on = 1'b0;
         if (start_req) begin
            nxt.frame_bits  = {~command, command, ~address, address};
            nxt.bits_left   = 6'd0;
            nxt.tick_count  = 16'd0;
            nxt.cycle_count = 10'd0;
            nxt.carrier_on  = 1'b1;
         end
      end
   end

   // result of the step
   always_comb begin
      res.led_level = nxt.carrier_on;
      res.busy_res  = nxt.phase != PH_IDLE;
      res.done_res  = stop_end;
   end

endmodule
`default_nettype wire

### rtl/nec_ir_frame_transmitter_core.sv
// NEC infrared frame transmitter: input register, sequencer step, result register.
// An accepted item waits in the input register until the result register is free; its result is then registered.
// Throughput: one item per cycle while rsp_stall does not hold the result; the sequencer state loops through state_ff.
// Stalls: rsp_stall holds the result register and backs up into req_stall.
// Reset (synchronous): idle, both item registers empty, registers at their defaults.
// csr_ready is always high; a write lands at the edge of its handshake.
`default_nettype none
module nec_ir_frame_transmitter_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_tick,
   input  logic                             req_start_req,
   input  logic [7:0]                       req_address,
   input  logic [7:0]                       req_command,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_led_level,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nirt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nirt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import nirt_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type step_res;
   result_type res_ff;
   logic       in_valid_ff;
   logic       out_valid_ff;
   logic       tick_ff;
   logic       start_ff;
   logic [7:0] address_ff;
   logic [7:0] command_ff;
   logic       out_free;
   logic       advance;
   logic       take_in;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign take_in   = req_valid && !req_stall;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.carrier_half_ticks <= RST_CARRIER_HALF;
         cfg_ff.leader_mark_cycles <= RST_LEAD_MARK;
         cfg_ff.leader_space_ticks <= RST_LEAD_SPACE;
         cfg_ff.bit_mark_cycles    <= RST_BIT_MARK;
         cfg_ff.unit_ticks         <= RST_UNIT;
         cfg_ff.lsb_first          <= RST_LSB_FIRST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CARRIER_HALF: cfg_ff.carrier_half_ticks <= csr_wdata[7:0];
            CSR_LEAD_MARK:    cfg_ff.leader_mark_cycles <= csr_wdata[9:0];
            CSR_LEAD_SPACE:   cfg_ff.leader_space_ticks <= csr_wdata;
            CSR_BIT_MARK:     cfg_ff.bit_mark_cycles    <= csr_wdata[7:0];
            CSR_UNIT:         cfg_ff.unit_ticks         <= csr_wdata[13:0];
            CSR_LSB_FIRST:    cfg_ff.lsb_first          <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_in) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         tick_ff    <= req_tick;
         start_ff   <= req_start_req;
         address_ff <= req_address;
         command_ff <= req_command;
      end
   end

   nirt_step u_step (
      .cfg       (cfg_ff),
      .cur       (state_ff),
      .tick      (tick_ff),
      .start_req (start_ff),
      .address   (address_ff),
      .command   (command_ff),
      .nxt       (state_in),
      .res       (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, default: '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) res_ff <= step_res;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_led_level = res_ff.led_level;
   assign rsp_busy_res  = res_ff.busy_res;
   assign rsp_done_res  = res_ff.done_res;

endmodule
`default_nettype wire

### rtl/nirt_checker.sv
// Port-level checks for the transmitter, bound to the top level.
`default_nettype none
`include "nec_ir_frame_transmitter_core_macros.svh"
module nirt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_led_level,
   input wire logic rsp_busy_res,
   input wire logic rsp_done_res
);

   `NIRT_CHECK_RST(a_reset_empties, reset |=> !rsp_valid, "result valid after reset")

   // the step that ends a frame already reports idle
   `NIRT_CHECK(a_done_idle, rsp_valid && rsp_done_res |-> !rsp_busy_res, "done while busy")

   // the LED is dark whenever no frame is running
   `NIRT_CHECK(a_idle_dark, rsp_valid && !rsp_busy_res |-> !rsp_led_level, "LED lit when idle")

   `NIRT_CHECK(a_stall_hold,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_led_level) &&
         $stable(rsp_busy_res) && $stable(rsp_done_res),
      "stalled result changed")

endmodule

bind nec_ir_frame_transmitter_core nirt_checker u_nirt_checker (.*);
`default_nettype wire
